// ===== hw/rtl/linear_adsr_envelope_unit_assert.svh =====
// assertion macros shared by the checker
`ifndef LINEAR_ADSR_ENVELOPE_UNIT_ASSERT_SVH
`define LINEAR_ADSR_ENVELOPE_UNIT_ASSERT_SVH

// same-cycle implication
`define LASE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LASE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lase_pkg.sv =====
package lase_pkg;

    localparam int STEP_W      = 24;
    localparam int GAIN_W      = 16;
    localparam int VEL_W       = 16;
    localparam int AMP_W       = 16;
    localparam int AMP_FRAC_W  = 15;
    localparam int MODE_W      = 3;
    localparam int PHASE_W     = 2;
    localparam int LEVEL_OUT_W = 24;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 3;

    localparam logic [AMP_W-1:0]  AMP_MAX    = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

    localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN    = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 3'd0,
        MODE_NOTE_ON  = 3'd1,
        MODE_NOTE_OFF = 3'd2,
        MODE_NOTE_CUT = 3'd3,
        MODE_VELOCITY = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        PH_ATTACK  = 4'b0001,
        PH_DECAY   = 4'b0010,
        PH_SUSTAIN = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    localparam logic [PHASE_W-1:0] PHASE_CODE_ATTACK  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DECAY   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_SUSTAIN = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_RELEASE = 2'd3;

    typedef struct packed {
        phase_t phase;
        logic   active;
    } env_ctrl_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        unique case (p)
            PH_ATTACK:  c = PHASE_CODE_ATTACK;
            PH_DECAY:   c = PHASE_CODE_DECAY;
            PH_SUSTAIN: c = PHASE_CODE_SUSTAIN;
            PH_RELEASE: c = PHASE_CODE_RELEASE;
            default:    c = PHASE_CODE_ATTACK;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/lase_step.sv =====
module lase_step #(
    parameter int LEVEL_FRAC_BITS = 23
) (
    input  logic [lase_pkg::MODE_W-1:0]  mode,
    input  logic [lase_pkg::AMP_W-1:0]   amp_new,
    input  logic [LEVEL_FRAC_BITS:0]     level,
    input  logic [lase_pkg::AMP_W-1:0]   amp,
    input  lase_pkg::env_ctrl_t          ctrl,
    input  logic [lase_pkg::STEP_W-1:0]  attack_step,
    input  logic [lase_pkg::STEP_W-1:0]  decay_step,
    input  logic [lase_pkg::STEP_W-1:0]  hold_level,
    input  logic [lase_pkg::STEP_W-1:0]  release_step,
    output logic [LEVEL_FRAC_BITS:0]     level_next,
    output logic [lase_pkg::AMP_W-1:0]   amp_next,
    output lase_pkg::env_ctrl_t          ctrl_next
);
    import lase_pkg::*;

    localparam int LVL_W   = LEVEL_FRAC_BITS + 1;
    localparam int ARITH_W = ((LVL_W > STEP_W) ? LVL_W : STEP_W) + 1;
    localparam logic [LVL_W-1:0] ONE = LVL_W'(1) << LEVEL_FRAC_BITS;

    logic [ARITH_W-1:0] lvl_x;
    logic [ARITH_W-1:0] one_x;
    logic [ARITH_W-1:0] sus_raw;
    logic [ARITH_W-1:0] sus_x;
    logic [ARITH_W-1:0] att_sum;
    logic [ARITH_W-1:0] dec_floor;
    logic [ARITH_W-1:0] dec_diff;
    logic [ARITH_W-1:0] rel_x;
    logic [ARITH_W-1:0] rel_diff;
    logic [LVL_W-1:0]   tick_level;
    env_ctrl_t          tick_ctrl;

    assign lvl_x     = ARITH_W'(level);
    assign one_x     = ARITH_W'(ONE);
    assign sus_raw   = ARITH_W'(hold_level);
    assign sus_x     = (sus_raw > one_x) ? one_x : sus_raw;
    assign att_sum   = lvl_x + ARITH_W'(attack_step);
    // compare against target plus step so nothing goes below zero
    assign dec_floor = sus_x + ARITH_W'(decay_step);
    assign dec_diff  = lvl_x - ARITH_W'(decay_step);
    assign rel_x     = ARITH_W'(release_step);
    assign rel_diff  = lvl_x - rel_x;

    always_comb begin
        tick_level = level;
        tick_ctrl  = ctrl;
        unique case (ctrl.phase)
            PH_ATTACK: begin
                if (att_sum >= one_x) begin
                    tick_level     = ONE;
                    tick_ctrl.phase = PH_DECAY;
                end else begin
                    tick_level = att_sum[LVL_W-1:0];
                end
            end
            PH_DECAY: begin
                if (lvl_x <= dec_floor) begin
                    tick_level      = sus_x[LVL_W-1:0];
                    tick_ctrl.phase = PH_SUSTAIN;
                end else begin
                    tick_level = dec_diff[LVL_W-1:0];
                end
            end
            PH_SUSTAIN: begin
                tick_level = sus_x[LVL_W-1:0];
            end
            PH_RELEASE: begin
                if (lvl_x <= rel_x) begin
                    tick_level       = '0;
                    tick_ctrl.active = 1'b0;
                end else begin
                    tick_level = rel_diff[LVL_W-1:0];
                end
            end
            default: begin
                tick_level = level;
            end
        endcase
    end

    always_comb begin
        level_next = level;
        amp_next   = amp;
        ctrl_next  = ctrl;
        unique case (mode)
            MODE_TICK: begin
                if (ctrl.active) begin
                    level_next = tick_level;
                    ctrl_next  = tick_ctrl;
                end
            end
            MODE_NOTE_ON: begin
                amp_next         = amp_new;
                level_next       = '0;
                ctrl_next.phase  = PH_ATTACK;
                ctrl_next.active = 1'b1;
            end
            MODE_NOTE_OFF: begin
                if (ctrl.active) begin
                    ctrl_next.phase = PH_RELEASE;
                end
            end
            MODE_NOTE_CUT: begin
                ctrl_next.active = 1'b0;
            end
            MODE_VELOCITY: begin
                amp_next = amp_new;
            end
            default: begin
                level_next = level;
            end
        endcase
    end

endmodule

// ===== hw/rtl/linear_adsr_envelope_unit.sv =====
// Linear ADSR envelope for one voice. Each request carries a mode (sample tick,
// note on, note off with release tail, immediate cut, velocity change) and a
// velocity; each returns one result with the level after the request, the level
// scaled by the stored amplitude, the active flag and the phase code. One request
// is taken every clock cycle when the result side keeps up. Its result comes
// from the velocity-times-gain product, the envelope state update and the
// level-times-amplitude product, each closed by a register. The state update
// is combinational into the state register, which is what allows a new request
// every cycle. The envelope registers at APB byte offsets 0x00 to 0x10 should be
// written only while the unit is idle. No start-up sweep after reset.
module linear_adsr_envelope_unit #(
    parameter int LEVEL_FRAC_BITS = 23
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lase_pkg::ADDR_W-1:0]          paddr,
    input  logic [lase_pkg::DATA_W-1:0]          pwdata,
    output logic [lase_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [lase_pkg::MODE_W-1:0]          s_mode,
    input  logic [lase_pkg::VEL_W-1:0]           s_velocity,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lase_pkg::LEVEL_OUT_W-1:0]     m_envelope_level,
    output logic [lase_pkg::AMP_W-1:0]           m_scaled_level,
    output logic                                 m_voice_active,
    output logic [lase_pkg::PHASE_W-1:0]         m_envelope_phase
);
    import lase_pkg::*;

    localparam int LVL_W  = LEVEL_FRAC_BITS + 1;
    localparam int PROD_W = LVL_W + AMP_W;
    localparam int AMPP_W = GAIN_W + VEL_W;
    localparam logic [STEP_W-1:0] STEP_RESET =
        (LEVEL_FRAC_BITS < STEP_W) ? (STEP_W'(1) << LEVEL_FRAC_BITS) : '0;

    // configuration
    logic [STEP_W-1:0]    attack_step_reg;
    logic [STEP_W-1:0]    decay_step_reg;
    logic [STEP_W-1:0]    hold_level_reg;
    logic [STEP_W-1:0]    release_step_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // pipeline control
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic m_valid_reg, m_valid_next;
    logic s_acc, s1_adv, s2_adv, s2_take, out_take;

    // stage 1 payload
    logic [MODE_W-1:0]  s1_mode_reg;
    logic [AMP_W-1:0]   s1_amp_reg;
    logic [AMPP_W-1:0]  amp_prod;
    logic [AMPP_W-1:0]  amp_raw;
    logic [AMP_W-1:0]   amp_sat;

    // envelope state, also the stage 2 result
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [AMP_W-1:0]   amplitude_reg, amplitude_next;
    env_ctrl_t          ctrl_reg, ctrl_next;

    // output stage
    logic [PROD_W-1:0]      scale_prod;
    logic [PROD_W-1:0]      scale_shift;
    logic [AMP_W-1:0]       scaled;
    logic [LEVEL_OUT_W-1:0] m_level_reg;
    logic [AMP_W-1:0]       m_scaled_reg;
    logic                   m_active_reg;
    logic [PHASE_W-1:0]     m_phase_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            REG_ATTACK:  prdata = DATA_W'(attack_step_reg);
            REG_DECAY:   prdata = DATA_W'(decay_step_reg);
            REG_SUSTAIN: prdata = DATA_W'(hold_level_reg);
            REG_RELEASE: prdata = DATA_W'(release_step_reg);
            REG_GAIN:    prdata = DATA_W'(gain_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_step_reg  <= STEP_RESET;
            decay_step_reg   <= STEP_RESET;
            hold_level_reg   <= STEP_RESET;
            release_step_reg <= STEP_RESET;
            gain_reg         <= GAIN_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ATTACK:  attack_step_reg  <= pwdata[STEP_W-1:0];
                REG_DECAY:   decay_step_reg   <= pwdata[STEP_W-1:0];
                REG_SUSTAIN: hold_level_reg   <= pwdata[STEP_W-1:0];
                REG_RELEASE: release_step_reg <= pwdata[STEP_W-1:0];
                REG_GAIN:    gain_reg         <= pwdata[GAIN_W-1:0];
                default:     gain_reg         <= gain_reg;
            endcase
        end
    end

    // handshake chain, output side first
    assign out_take = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_take;
    assign s2_take  = !s2_valid_reg || out_take;
    assign s1_adv   = s1_valid_reg && s2_take;
    assign s_ready  = !s1_valid_reg || s2_take;
    assign s_acc    = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s_acc  ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        m_valid_next  = s2_adv ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // amplitude = gain * velocity, saturated at full scale
    assign amp_prod = AMPP_W'(gain_reg) * AMPP_W'(s_velocity);
    assign amp_raw  = amp_prod >> AMP_FRAC_W;
    assign amp_sat  = (amp_raw > AMPP_W'(AMP_MAX)) ? AMP_MAX : amp_raw[AMP_W-1:0];

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_mode_reg <= s_mode;
            s1_amp_reg  <= amp_sat;
        end
    end

    lase_step #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_step (
        .mode          (s1_mode_reg),
        .amp_new       (s1_amp_reg),
        .level         (level_reg),
        .amp           (amplitude_reg),
        .ctrl          (ctrl_reg),
        .attack_step   (attack_step_reg),
        .decay_step    (decay_step_reg),
        .hold_level    (hold_level_reg),
        .release_step  (release_step_reg),
        .level_next    (level_next),
        .amp_next      (amplitude_next),
        .ctrl_next     (ctrl_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            level_reg     <= '0;
            amplitude_reg <= '0;
            ctrl_reg      <= '{phase: PH_ATTACK, active: 1'b0};
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
            // state only moves once the previous result has left stage 2
            if (s1_adv) begin
                level_reg     <= level_next;
                amplitude_reg <= amplitude_next;
                ctrl_reg      <= ctrl_next;
            end
        end
    end

    assign scale_prod  = PROD_W'(level_reg) * PROD_W'(amplitude_reg);
    assign scale_shift = scale_prod >> LEVEL_FRAC_BITS;

    always_comb begin
        if (!ctrl_reg.active) begin
            scaled = '0;
        end else if (scale_shift > PROD_W'(AMP_MAX)) begin
            scaled = AMP_MAX;
        end else begin
            scaled = scale_shift[AMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_level_reg  <= LEVEL_OUT_W'(level_reg);
            m_scaled_reg <= scaled;
            m_active_reg <= ctrl_reg.active;
            m_phase_reg  <= phase_code(ctrl_reg.phase);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_envelope_level = m_level_reg;
    assign m_scaled_level   = m_scaled_reg;
    assign m_voice_active   = m_active_reg;
    assign m_envelope_phase = m_phase_reg;

endmodule

// ===== hw/rtl/lase_checker.sv =====
`include "linear_adsr_envelope_unit_assert.svh"

module lase_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [lase_pkg::LEVEL_OUT_W-1:0]  m_envelope_level,
    input logic [lase_pkg::AMP_W-1:0]        m_scaled_level,
    input logic                              m_voice_active,
    input logic [lase_pkg::PHASE_W-1:0]      m_envelope_phase
);
    import lase_pkg::*;

    // a stalled result keeps its payload
    `LASE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_envelope_level) && $stable(m_scaled_level) && $stable(m_voice_active) && $stable(m_envelope_phase), "result changed while stalled")

    // the input side only backs up when the output side is full and stalled
    `LASE_ASSERT_NOW(a_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without output stall")

    `LASE_ASSERT_NOW(a_silent_inactive, aclk, aresetn, m_valid && !m_voice_active, m_scaled_level == '0, "inactive voice with nonzero output")

    `LASE_ASSERT_NOW(a_scaled_range, aclk, aresetn, m_valid, m_scaled_level <= AMP_MAX, "scaled level above full scale")

endmodule

bind linear_adsr_envelope_unit lase_checker u_lase_checker (.*);

// ===== verif/linear_adsr_envelope_unit_tb.sv =====
`timescale 1ns / 100ps

module linear_adsr_envelope_unit_tb;
    import lase_pkg::*;

    localparam int     LEVEL_FRAC       = 23;
    localparam longint LVL_ONE          = longint'(1) << LEVEL_FRAC;
    localparam int     CYCLE_LIMIT      = 1000000;
    localparam int     LONG_STALL       = 400;
    localparam int     SETTLE_CYCLES    = 8;
    localparam int     NOTE_SETTINGS    = 8;
    localparam int     REQS_PER_SETTING = 140;

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        logic [AMP_W-1:0]       scaled;
        logic                   active;
        logic [PHASE_W-1:0]     phase;
    } envelope_out_t;

    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [ADDR_W-1:0]      paddr      = '0;
    logic [DATA_W-1:0]      pwdata     = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic [MODE_W-1:0]      s_mode     = '0;
    logic [VEL_W-1:0]       s_velocity = '0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic [LEVEL_OUT_W-1:0] m_envelope_level;
    logic [AMP_W-1:0]       m_scaled_level;
    logic                   m_voice_active;
    logic [PHASE_W-1:0]     m_envelope_phase;

    // predictor copy of the registers and the voice
    logic [STEP_W-1:0]  cfg_attack  = 24'd8388608;
    logic [STEP_W-1:0]  cfg_decay   = 24'd8388608;
    logic [STEP_W-1:0]  cfg_sustain = 24'd8388608;
    logic [STEP_W-1:0]  cfg_release = 24'd8388608;
    logic [GAIN_W-1:0]  cfg_gain    = GAIN_RESET;
    logic [PHASE_W-1:0] env_phase   = PHASE_CODE_ATTACK;
    logic [STEP_W-1:0]  env_level   = '0;
    logic [AMP_W-1:0]   env_amp     = '0;
    logic               env_active  = 1'b0;

    envelope_out_t awaited_envelopes[$];
    envelope_out_t oldest_envelope;

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    int  cycle_count     = 0;
    bit  idle_enable     = 1'b1;
    int  long_stall_req  = 0;
    int  long_stall_seen = 0;
    int  long_stall_left = 0;
    int  rx_run_left     = 0;
    int  rx_stall_left   = 0;

    linear_adsr_envelope_unit #(
        .LEVEL_FRAC_BITS(LEVEL_FRAC)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_velocity       (s_velocity),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_envelope_level (m_envelope_level),
        .m_scaled_level   (m_scaled_level),
        .m_voice_active   (m_voice_active),
        .m_envelope_phase (m_envelope_phase)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (!idle_enable) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VEL_W-1:0] rand_velocity();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] pick_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return 24'd1;
        if (r == 2) return 24'hFFFFFF;
        if (r == 3) return 24'(LVL_ONE);
        return 24'(LVL_ONE / $urandom_range(2, 48) + $urandom_range(0, 255));
    endfunction

    function automatic logic [AMP_W-1:0] gain_amplitude(input logic [VEL_W-1:0] vel);
        longint prod;
        prod = (longint'(cfg_gain) * longint'(vel)) >> AMP_FRAC_W;
        return (prod > longint'(AMP_MAX)) ? AMP_MAX : AMP_W'(prod);
    endfunction

    // applies one request to the voice copy and returns the result it should give
    function automatic envelope_out_t predict_envelope(input logic [MODE_W-1:0] mode,
                                                       input logic [VEL_W-1:0]  vel);
        longint        lvl;
        longint        sus;
        longint        prod;
        envelope_out_t res;
        case (mode)
            MODE_TICK: begin
                if (env_active) begin
                    lvl = env_level;
                    sus = (cfg_sustain > LVL_ONE) ? LVL_ONE : longint'(cfg_sustain);
                    case (env_phase)
                        PHASE_CODE_ATTACK: begin
                            lvl += cfg_attack;
                            if (lvl >= LVL_ONE) begin
                                lvl = LVL_ONE;
                                env_phase = PHASE_CODE_DECAY;
                            end
                        end
                        PHASE_CODE_DECAY: begin
                            lvl -= cfg_decay;
                            if (lvl <= sus) begin
                                lvl = sus;
                                env_phase = PHASE_CODE_SUSTAIN;
                            end
                        end
                        PHASE_CODE_SUSTAIN: begin
                            lvl = sus;
                        end
                        default: begin
                            lvl -= cfg_release;
                            if (lvl <= 0) begin
                                lvl = 0;
                                env_active = 1'b0;
                            end
                        end
                    endcase
                    env_level = STEP_W'(lvl);
                end
            end
            MODE_NOTE_ON: begin
                env_amp    = gain_amplitude(vel);
                env_level  = '0;
                env_phase  = PHASE_CODE_ATTACK;
                env_active = 1'b1;
            end
            MODE_NOTE_OFF: begin
                if (env_active && env_phase != PHASE_CODE_RELEASE) env_phase = PHASE_CODE_RELEASE;
            end
            MODE_NOTE_CUT: begin
                env_active = 1'b0;
            end
            MODE_VELOCITY: begin
                env_amp = gain_amplitude(vel);
            end
            default: begin
            end
        endcase
        prod = 0;
        if (env_active) begin
            prod = (longint'(env_level) * longint'(env_amp)) >> LEVEL_FRAC;
            if (prod > longint'(AMP_MAX)) prod = AMP_MAX;
        end
        res.level  = env_level;
        res.scaled = AMP_W'(prod);
        res.active = env_active;
        res.phase  = env_phase;
        return res;
    endfunction

    // one request: payload up, wait for the handshake, then maybe an idle gap
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [VEL_W-1:0] vel);
        int gap;
        s_mode     <= mode;
        s_velocity <= vel;
        if (!s_valid) s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_envelopes.push_back(predict_envelope(mode, vel));
        requests_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_noise();
        send_request(MODE_W'($urandom_range(0, 7)), rand_velocity());
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_envelopes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [REG_IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] expected);
        logic [DATA_W-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== expected) begin
            $error("register %0d readback: expected %0d, actual %0d", idx, expected, rdata);
            error_count++;
        end
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] stored;
        logic [DATA_W-1:0] rdata;
        stored = (idx == REG_GAIN) ? {16'd0, value[15:0]} : {8'd0, value[23:0]};
        apb_access(1'b1, idx, stored, rdata);
        case (idx)
            REG_ATTACK:  cfg_attack  = stored[STEP_W-1:0];
            REG_DECAY:   cfg_decay   = stored[STEP_W-1:0];
            REG_SUSTAIN: cfg_sustain = stored[STEP_W-1:0];
            REG_RELEASE: cfg_release = stored[STEP_W-1:0];
            default:     cfg_gain    = stored[GAIN_W-1:0];
        endcase
        check_register(idx, stored);
    endtask

    task automatic write_all_registers(input logic [STEP_W-1:0] attack,
                                       input logic [STEP_W-1:0] decay,
                                       input logic [STEP_W-1:0] sustain,
                                       input logic [STEP_W-1:0] release_val,
                                       input logic [GAIN_W-1:0] gain);
        write_register(REG_ATTACK, DATA_W'(attack));
        write_register(REG_DECAY, DATA_W'(decay));
        write_register(REG_SUSTAIN, DATA_W'(sustain));
        write_register(REG_RELEASE, DATA_W'(release_val));
        write_register(REG_GAIN, DATA_W'(gain));
        settings_used++;
    endtask

    task automatic test_register_reset();
        check_register(REG_ATTACK, 32'd8388608);
        check_register(REG_DECAY, 32'd8388608);
        check_register(REG_SUSTAIN, 32'd8388608);
        check_register(REG_RELEASE, 32'd8388608);
        check_register(REG_GAIN, DATA_W'(GAIN_RESET));
    endtask

    // reset settings: every step is full scale, so attack, decay and release each last one tick
    task automatic test_directed_modes();
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_NOTE_OFF, 16'd0);
        send_request(MODE_NOTE_CUT, 16'hFFFF);
        send_request(MODE_VELOCITY, 16'hFFFF);
        send_request(3'd5, 16'd0);
        send_request(MODE_NOTE_ON, 16'd32768);
        send_request(MODE_TICK, 16'hFFFF);
        send_request(MODE_VELOCITY, 16'd16384);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_NOTE_OFF, 16'd0);
        send_request(MODE_NOTE_OFF, 16'd0);
        send_request(MODE_VELOCITY, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_NOTE_ON, 16'hFFFF);
        send_request(3'd6, 16'h5555);
        send_request(3'd7, 16'hAAAA);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_NOTE_CUT, 16'd0);
        send_request(MODE_NOTE_OFF, 16'd0);
        send_request(MODE_NOTE_ON, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_VELOCITY, 16'd1);
        wait_drained();
    endtask

    // zero steps hold the phase, oversized sustain clamps to full scale
    task automatic test_special_settings();
        write_all_registers('0, '0, '0, '0, 16'hFFFF);
        send_request(MODE_NOTE_ON, 16'hFFFF);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_TICK, 16'd0);
        wait_drained();
        write_register(REG_ATTACK, 32'h00FF_FFFF);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_NOTE_OFF, 16'd0);
        send_request(MODE_TICK, 16'd0);
        wait_drained();
        write_register(REG_RELEASE, 32'd1);
        send_request(MODE_TICK, 16'd0);
        wait_drained();
        write_register(REG_RELEASE, 32'h00FF_FFFF);
        send_request(MODE_TICK, 16'd0);
        wait_drained();
        write_all_registers(24'd8388608, 24'd1, 24'hFFFFFF, 24'd1, 16'd32768);
        send_request(MODE_NOTE_ON, 16'd32768);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_TICK, 16'd0);
        send_request(MODE_NOTE_OFF, 16'd0);
        send_request(MODE_TICK, 16'd0);
        wait_drained();
    endtask

    // one note: on, ticks with noise, off or cut, then ticks through release
    task automatic play_note();
        int n;
        int k;
        send_request(MODE_NOTE_ON, rand_velocity());
        n = $urandom_range(0, 70);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_request(MODE_TICK, 16'($urandom));
        end
        if ($urandom_range(0, 5) == 0) send_request(MODE_NOTE_CUT, 16'($urandom));
        else send_request(MODE_NOTE_OFF, 16'($urandom));
        n = $urandom_range(0, 40);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) send_noise();
            else send_request(MODE_TICK, 16'($urandom));
        end
    endtask

    task automatic test_random_notes();
        int s;
        int goal;
        for (s = 0; s < NOTE_SETTINGS; s++) begin
            wait_drained();
            case (s)
                0: write_all_registers(24'd1, 24'd1, '0, 24'd1, '0);
                1: write_all_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                       16'hFFFF);
                default: write_all_registers(pick_step(), pick_step(),
                                             ($urandom_range(0, 4) == 0) ?
                                                 24'($urandom_range(8388608, 16777215)) :
                                                 24'($urandom_range(0, 8388608)),
                                             pick_step(), 16'($urandom));
            endcase
            idle_enable = (s != 3);
            goal = requests_sent + REQS_PER_SETTING;
            while (requests_sent < goal) begin
                if ($urandom_range(0, 7) == 0) send_noise();
                else play_note();
            end
        end
        idle_enable = 1'b1;
        wait_drained();
    endtask

    // result side held off while requests keep coming, then a full drain
    task automatic test_backpressure();
        int k;
        write_all_registers(24'd300000, 24'd200000, 24'd3000000, 24'd150000, 16'd30000);
        idle_enable = 1'b0;
        long_stall_req++;
        send_request(MODE_NOTE_ON, rand_velocity());
        for (k = 0; k < 60; k++) send_request(MODE_TICK, 16'($urandom));
        wait_drained();
        idle_enable = 1'b1;
        send_request(MODE_NOTE_OFF, 16'd0);
        for (k = 0; k < 40; k++) send_request(MODE_TICK, 16'($urandom));
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (long_stall_seen != long_stall_req) begin
            long_stall_seen = long_stall_req;
            long_stall_left = LONG_STALL;
        end
        if (long_stall_left > 0) begin
            m_ready <= 1'b0;
            long_stall_left--;
        end else if (!idle_enable) begin
            m_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_run_left > 0) begin
            m_ready <= 1'b1;
            rx_run_left--;
        end else begin
            rx_run_left   = $urandom_range(1, 16);
            rx_stall_left = pick_gap();
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_envelopes.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                oldest_envelope = awaited_envelopes.pop_front();
                results_checked++;
                if (m_envelope_level !== oldest_envelope.level) begin
                    $error("envelope_level mismatch: expected %0d, actual %0d",
                           oldest_envelope.level, m_envelope_level);
                    error_count++;
                end
                if (m_scaled_level !== oldest_envelope.scaled) begin
                    $error("scaled_level mismatch: expected %0d, actual %0d",
                           oldest_envelope.scaled, m_scaled_level);
                    error_count++;
                end
                if (m_voice_active !== oldest_envelope.active) begin
                    $error("voice_active mismatch: expected %0d, actual %0d",
                           oldest_envelope.active, m_voice_active);
                    error_count++;
                end
                if (m_envelope_phase !== oldest_envelope.phase) begin
                    $error("envelope_phase mismatch: expected %0d, actual %0d",
                           oldest_envelope.phase, m_envelope_phase);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_envelopes.size());
            $display("linear_adsr_envelope_unit_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_reset();
        test_directed_modes();
        test_special_settings();
        test_random_notes();
        test_backpressure();
        wait_drained();
        $display("checked %0d results from %0d requests over %0d register settings",
                 results_checked, requests_sent, settings_used);
        $display("random gaps on both sides, a %0d-cycle result stall and a full drain",
                 LONG_STALL);
        if (error_count == 0 && awaited_envelopes.size() == 0) begin
            $display("linear_adsr_envelope_unit_tb passed");
        end else begin
            $display("linear_adsr_envelope_unit_tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lase_pkg.sv
hw/rtl/lase_step.sv
hw/rtl/linear_adsr_envelope_unit.sv
hw/rtl/lase_checker.sv
verif/linear_adsr_envelope_unit_tb.sv
